// ===== rtl/core/alist_pkg.sv =====
// shared types and constants for the array list engine
package alist_pkg;

    localparam int CAPACITY    = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = 8;
    localparam int CNT_W       = 9;
    localparam int ROT_W       = 16;

    typedef enum logic [2:0] {
        OP_INSERT         = 3'd0,
        OP_REMOVE         = 3'd1,
        OP_FIND           = 3'd2,
        OP_ROTATE_RIGHT   = 3'd3,
        OP_ROTATE_LEFT    = 3'd4,
        OP_FIND_TRANSPOSE = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_SCAN,
        S_COPY,
        S_FILL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]                    opcode;
        logic signed [VALUE_WIDTH-1:0] item_value;
        logic [CNT_W-1:0]              position;
        logic [ROT_W-1:0]              rotate_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] result_index;
        logic [CNT_W-1:0]  list_length;
    } out_item_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] remainder;
    } div_out_t;

endpackage

// ===== rtl/core/alist_bank.sv =====
// one bank of entry storage, one write port and one registered read port
module alist_bank
    import alist_pkg::*;
(
    input  logic                   clk,
    input  logic                   we,
    input  logic [ADDR_W-1:0]      waddr,
    input  logic [VALUE_WIDTH-1:0] wdata,
    input  logic [ADDR_W-1:0]      raddr,
    output logic [VALUE_WIDTH-1:0] rdata
);

    logic [VALUE_WIDTH-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/alist_divider.sv =====
// bit-serial remainder of the rotate count by the list length
module alist_divider
    import alist_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [ROT_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output div_out_t         div_out
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [3:0]       step_reg, step_next;
    logic [ROT_W-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, dvd_reg[ROT_W-1]};
        if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                trial = trial - {1'b0, dsr_reg};
            end
            rem_next  = trial[CNT_W-1:0];
            dvd_next  = {dvd_reg[ROT_W-2:0], 1'b0};
            step_next = step_reg + 4'd1;
            if (step_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (go)
        begin
            busy_next = 1'b1;
            step_next = 4'd0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign div_out.done      = done_reg;
    assign div_out.remainder = rem_reg;

endmodule

// ===== rtl/core/array_list_engine_unit.sv =====
// top level: list control, two ping-pong entry banks and the count divider
//
// A command is taken when start is high and busy is low; busy then stays high until the
// single result has been shown on result for one cycle with result_valid, and the receiver
// must take it in that cycle. Find scans the list until a hit or the end of the list;
// remove and rotate left copy the list into the other bank, and insert copies and then
// writes the new entry; find-transpose with a swap scans and then copies; rotate right
// first reduces the count modulo the length in the divider and then copies, or ends there
// when the count reduces to zero. The longest command is find-transpose matching the last
// of 256 entries. Error cases, short-list rotations and unused opcodes go straight to the
// result, and the next command can be taken in the cycle after the result.
module array_list_engine_unit
    import alist_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  request,
    output logic      result_valid,
    output out_item_t result
);

    state_t                 state_reg, state_next;
    logic [2:0]             op_reg, op_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   bank_reg, bank_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       found_reg, found_next;
    logic [CNT_W-1:0]       rot_reg, rot_next;
    status_t                status_reg, status_next;
    logic [ADDR_W-1:0]      ridx_reg, ridx_next;
    logic                   rdv_reg, rdv_next;
    logic [CNT_W-1:0]       rdidx_reg, rdidx_next;

    logic                   rd_en;
    logic                   copy_wr;
    logic [CNT_W-1:0]       dest;
    logic                   wr_en;
    logic                   wr_bank;
    logic [ADDR_W-1:0]      wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [VALUE_WIDTH-1:0] rdata0, rdata1, rdata;
    logic                   div_go;
    div_out_t               div_out;

    alist_bank u_bank0 (
        .clk   (clk),
        .we    (wr_en && !wr_bank),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rdata0)
    );

    alist_bank u_bank1 (
        .clk   (clk),
        .we    (wr_en && wr_bank),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rdata1)
    );

    alist_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (request.rotate_count),
        .divisor  (count_reg),
        .div_out  (div_out)
    );

    assign rdata   = bank_reg ? rdata1 : rdata0;
    assign rd_en   = ((state_reg == S_SCAN) || (state_reg == S_COPY)) && (idx_reg < count_reg);
    assign copy_wr = (state_reg == S_COPY) && rdv_reg
                     && !((opcode_t'(op_reg) == OP_REMOVE) && (rdidx_reg == pos_reg));

    // outputs and memory control
    always_comb
    begin
        case (opcode_t'(op_reg))
            OP_INSERT:
                dest = (rdidx_reg < pos_reg) ? rdidx_reg : rdidx_reg + 9'd1;
            OP_REMOVE:
                dest = (rdidx_reg < pos_reg) ? rdidx_reg : rdidx_reg - 9'd1;
            OP_FIND_TRANSPOSE:
                if (rdidx_reg == found_reg)
                    dest = found_reg - 9'd1;
                else if (rdidx_reg == found_reg - 9'd1)
                    dest = found_reg;
                else
                    dest = rdidx_reg;
            default:
                dest = rot_reg;
        endcase

        if (state_reg == S_FILL)
        begin
            wr_en   = 1'b1;
            wr_bank = bank_reg;
            wr_addr = pos_reg[ADDR_W-1:0];
            wr_data = val_reg;
        end
        else
        begin
            wr_en   = copy_wr;
            wr_bank = !bank_reg;
            wr_addr = dest[ADDR_W-1:0];
            wr_data = rdata;
        end

        div_go = (state_reg == S_IDLE) && start
                 && (opcode_t'(request.opcode) == OP_ROTATE_RIGHT) && (count_reg >= 9'd2);

        busy                = (state_reg != S_IDLE);
        result_valid        = (state_reg == S_DONE);
        result.status       = status_reg;
        result.result_index = ridx_reg;
        result.list_length  = count_reg;
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        bank_next   = bank_reg;
        idx_next    = idx_reg + {{(CNT_W-1){1'b0}}, rd_en};
        found_next  = found_reg;
        rot_next    = rot_reg;
        status_next = status_reg;
        ridx_next   = ridx_reg;
        rdv_next    = rd_en;
        rdidx_next  = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = request.opcode;
                    val_next    = request.item_value;
                    pos_next    = request.position;
                    status_next = ST_OK;
                    ridx_next   = '0;
                    idx_next    = '0;
                    state_next  = S_DONE;
                    case (opcode_t'(request.opcode))
                        OP_INSERT:
                            if (count_reg >= 9'(CAPACITY))
                                status_next = ST_FULL;
                            else if (request.position > count_reg)
                                status_next = ST_BAD_INDEX;
                            else
                                state_next = S_COPY;
                        OP_REMOVE:
                            if (request.position >= count_reg)
                                status_next = ST_BAD_INDEX;
                            else
                            begin
                                ridx_next  = request.position[ADDR_W-1:0];
                                state_next = S_COPY;
                            end
                        OP_FIND, OP_FIND_TRANSPOSE:
                            state_next = S_SCAN;
                        OP_ROTATE_RIGHT:
                            if (count_reg >= 9'd2)
                                state_next = S_DIVIDE;
                        OP_ROTATE_LEFT:
                            if (count_reg >= 9'd2)
                            begin
                                rot_next   = count_reg - 9'd1;
                                state_next = S_COPY;
                            end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_DIVIDE:
            begin
                if (div_out.done)
                begin
                    rot_next   = div_out.remainder;
                    state_next = (div_out.remainder == '0) ? S_DONE : S_COPY;
                end
            end
            S_SCAN:
            begin
                if (rdv_reg && (rdata == val_reg))
                begin
                    found_next = rdidx_reg;
                    ridx_next  = rdidx_reg[ADDR_W-1:0];
                    state_next = S_DONE;
                    if ((opcode_t'(op_reg) == OP_FIND_TRANSPOSE) && (rdidx_reg != '0))
                    begin
                        ridx_next  = 8'(rdidx_reg - 9'd1);
                        idx_next   = '0;
                        rdv_next   = 1'b0;
                        state_next = S_COPY;
                    end
                end
                else if (!rdv_reg && (idx_reg >= count_reg))
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
            end
            S_COPY:
            begin
                if (copy_wr)
                begin
                    rot_next = (rot_reg + 9'd1 == count_reg) ? '0 : rot_reg + 9'd1;
                end
                if (!rdv_reg && (idx_reg >= count_reg))
                begin
                    bank_next = !bank_reg;
                    if (opcode_t'(op_reg) == OP_INSERT)
                        state_next = S_FILL;
                    else
                        state_next = S_DONE;
                    if (opcode_t'(op_reg) == OP_REMOVE)
                        count_next = count_reg - 9'd1;
                end
            end
            S_FILL:
            begin
                count_next = count_reg + 9'd1;
                state_next = S_DONE;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            bank_reg  <= 1'b0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            bank_reg  <= bank_next;
            rdv_reg   <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        rot_reg    <= rot_next;
        status_reg <= status_next;
        ridx_reg   <= ridx_next;
        rdidx_reg  <= rdidx_next;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 9'(CAPACITY))
        else $error("list length beyond capacity");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_busy_ends_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(result_valid))
        else $error("transfer finished without a result");

    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> busy)
        else $error("bank write while idle");

    a_count_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> $stable(count_reg))
        else $error("list length changed while idle");
`endif

endmodule
